// File: rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int unsigned HUE_W   = 9;
    localparam int unsigned FIX_W   = 9;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned SCALE_W = 16;
    localparam int unsigned K_W     = 14;
    localparam int unsigned PROD_W  = 30;
    localparam int unsigned QUO_W   = 12;
    localparam int unsigned RCPP_W  = 24;
    localparam int unsigned SECT_W  = 3;
    localparam int unsigned REM_W   = 6;

    localparam int unsigned DENOM_SHIFT = 18;
    localparam int unsigned RCP_SHIFT   = 16;

    localparam logic [HUE_W-1:0]  FULL_CIRCLE = 9'd360;
    localparam logic [FIX_W-1:0]  ONE_FIX     = 9'd256;
    localparam logic [REM_W-1:0]  SECTOR_DEG  = 6'd60;
    localparam logic [K_W-1:0]    SF_UNIT     = 14'd15360;
    localparam logic [PROD_W-1:0] HALF_DENOM  = 30'd1966080;
    // 4370 / 65536 approximates 1/15 closely enough for quotients up to 255
    localparam logic [RCPP_W-1:0] RCP_15      = 24'd4370;

    localparam logic [SECT_W-1:0] SECTOR_RY = 3'd0;
    localparam logic [SECT_W-1:0] SECTOR_YG = 3'd1;
    localparam logic [SECT_W-1:0] SECTOR_GC = 3'd2;
    localparam logic [SECT_W-1:0] SECTOR_CB = 3'd3;
    localparam logic [SECT_W-1:0] SECTOR_BM = 3'd4;
    localparam logic [SECT_W-1:0] SECTOR_MR = 3'd5;

    typedef struct packed {
        logic ld_mul;
        logic ld_rcp;
        logic ld_out;
    } stage_en_t;

    function automatic logic [HUE_W-1:0] sector_base(input logic [SECT_W-1:0] sect);
        logic [HUE_W-1:0] base;
        case (sect)
            SECTOR_RY: base = 9'd0;
            SECTOR_YG: base = 9'd60;
            SECTOR_GC: base = 9'd120;
            SECTOR_CB: base = 9'd180;
            SECTOR_BM: base = 9'd240;
            default:   base = 9'd300;
        endcase
        return base;
    endfunction

endpackage

// File: rtl/hsvrgb_chan.sv
`timescale 1ns / 1ps

module hsvrgb_chan
    import hsvrgb_pkg::*;
(
    input  logic               aclk,
    input  stage_en_t          en,
    input  logic [SCALE_W-1:0] scale_i,
    input  logic [K_W-1:0]     k_i,
    output logic [CHAN_W-1:0]  chan_o
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_rnd;
    logic [QUO_W-1:0]  quo;
    logic [RCPP_W-1:0] rcp_reg;
    logic [RCPP_W-1:0] rcp_next;
    logic [CHAN_W-1:0] chan_reg;
    logic [CHAN_W-1:0] chan_next;

    assign prod_next = PROD_W'(scale_i) * PROD_W'(k_i);

    // round half up over 2^18 * 15: shift first, then divide by 15
    assign prod_rnd  = prod_reg + HALF_DENOM;
    assign quo       = prod_rnd[PROD_W-1:DENOM_SHIFT];
    assign rcp_next  = RCPP_W'(quo) * RCP_15;
    assign chan_next = rcp_reg[RCP_SHIFT +: CHAN_W];

    always_ff @(posedge aclk) begin
        if (en.ld_mul) begin
            prod_reg <= prod_next;
        end
        if (en.ld_rcp) begin
            rcp_reg <= rcp_next;
        end
        if (en.ld_out) begin
            chan_reg <= chan_next;
        end
    end

    assign chan_o = chan_reg;

endmodule

// File: rtl/hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// HSV to RGB color converter, one color word per clock while m_tready is high.
// Input stream (s_): hue in whole degrees (360 and above read as 0),
// saturation and brightness with 8 fraction bits (values above 256 clip to 1.0).
// Output stream (m_): red, green and blue, each 0..255 rounded half up.
// Pipeline of five register stages: clamp and sector split, coefficient
// selection, channel multiply, rounding with divide-by-15 reciprocal,
// output register. An accepted word passes through these registers in
// order, and m_tvalid rises once it reaches the output register.
// Throughput is one word per clock while m_tready is high; every stage
// has its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles collapse and s_tready stays high while any stage is free.
// When m_tready is low the output word holds and the stages behind it
// fill up; s_tready drops only once all five stages hold a word.
// A synchronous active-low aresetn clears all valid bits; no word is
// lost or repeated across a stall.

module hsv_to_rgb_converter_core
    import hsvrgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue_deg[8:0], saturation[17:9], brightness[26:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    logic [HUE_W-1:0] hue_in;
    logic [FIX_W-1:0] sat_in;
    logic [FIX_W-1:0] bri_in;

    logic [HUE_W-1:0]   hue_cl;
    logic [FIX_W-1:0]   sat_cl;
    logic [FIX_W-1:0]   bri_cl;
    logic [SECT_W-1:0]  sect_next;
    logic [HUE_W-1:0]   rem_wide;
    logic [SCALE_W:0]   scale_wide;

    logic [SECT_W-1:0]  sect_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [FIX_W-1:0]   sat_reg;
    logic [SCALE_W-1:0] scale1_reg;

    logic [K_W-1:0]     kp, kq, kt, srem, strem;
    logic [K_W-1:0]     kr_next, kg_next, kb_next;
    logic [K_W-1:0]     kr_reg, kg_reg, kb_reg;
    logic [SCALE_W-1:0] scale2_reg;

    stage_en_t          chan_en;
    logic [CHAN_W-1:0]  red_out, green_out, blue_out;

    assign adv5 = !vld5_reg || m_tready;
    assign adv4 = !vld4_reg || adv5;
    assign adv3 = !vld3_reg || adv4;
    assign adv2 = !vld2_reg || adv3;
    assign adv1 = !vld1_reg || adv2;

    assign s_tready = adv1;
    assign m_tvalid = vld5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else begin
            if (adv1) begin
                vld1_reg <= s_tvalid;
            end
            if (adv2) begin
                vld2_reg <= vld1_reg;
            end
            if (adv3) begin
                vld3_reg <= vld2_reg;
            end
            if (adv4) begin
                vld4_reg <= vld3_reg;
            end
            if (adv5) begin
                vld5_reg <= vld4_reg;
            end
        end
    end

    // stage 1: clamp, sector split, 255 * b
    assign hue_in = s_tdata[8:0];
    assign sat_in = s_tdata[17:9];
    assign bri_in = s_tdata[26:18];

    always_comb begin
        hue_cl = (hue_in >= FULL_CIRCLE) ? '0 : hue_in;
        sat_cl = (sat_in > ONE_FIX) ? ONE_FIX : sat_in;
        bri_cl = (bri_in > ONE_FIX) ? ONE_FIX : bri_in;
        if (hue_cl >= sector_base(SECTOR_MR)) begin
            sect_next = SECTOR_MR;
        end else if (hue_cl >= sector_base(SECTOR_BM)) begin
            sect_next = SECTOR_BM;
        end else if (hue_cl >= sector_base(SECTOR_CB)) begin
            sect_next = SECTOR_CB;
        end else if (hue_cl >= sector_base(SECTOR_GC)) begin
            sect_next = SECTOR_GC;
        end else if (hue_cl >= sector_base(SECTOR_YG)) begin
            sect_next = SECTOR_YG;
        end else begin
            sect_next = SECTOR_RY;
        end
        rem_wide   = hue_cl - sector_base(sect_next);
        scale_wide = {bri_cl, 8'h00} - {8'h00, bri_cl};
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            sect_reg   <= sect_next;
            rem_reg    <= rem_wide[REM_W-1:0];
            sat_reg    <= sat_cl;
            scale1_reg <= scale_wide[SCALE_W-1:0];
        end
    end

    // stage 2: p, q, t coefficients and sector permutation
    always_comb begin
        kp    = K_W'(ONE_FIX - sat_reg) * K_W'(SECTOR_DEG);
        srem  = K_W'(sat_reg) * K_W'(rem_reg);
        strem = K_W'(sat_reg) * K_W'(SECTOR_DEG - rem_reg);
        kq    = SF_UNIT - srem;
        kt    = SF_UNIT - strem;
        case (sect_reg)
            SECTOR_RY: begin
                kr_next = SF_UNIT; kg_next = kt;      kb_next = kp;
            end
            SECTOR_YG: begin
                kr_next = kq;      kg_next = SF_UNIT; kb_next = kp;
            end
            SECTOR_GC: begin
                kr_next = kp;      kg_next = SF_UNIT; kb_next = kt;
            end
            SECTOR_CB: begin
                kr_next = kp;      kg_next = kq;      kb_next = SF_UNIT;
            end
            SECTOR_BM: begin
                kr_next = kt;      kg_next = kp;      kb_next = SF_UNIT;
            end
            default: begin
                kr_next = SF_UNIT; kg_next = kp;      kb_next = kq;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            kr_reg     <= kr_next;
            kg_reg     <= kg_next;
            kb_reg     <= kb_next;
            scale2_reg <= scale1_reg;
        end
    end

    // stages 3 to 5 per channel
    assign chan_en.ld_mul = adv3;
    assign chan_en.ld_rcp = adv4;
    assign chan_en.ld_out = adv5;

    hsvrgb_chan u_red (
        .aclk    (aclk),
        .en      (chan_en),
        .scale_i (scale2_reg),
        .k_i     (kr_reg),
        .chan_o  (red_out)
    );

    hsvrgb_chan u_green (
        .aclk    (aclk),
        .en      (chan_en),
        .scale_i (scale2_reg),
        .k_i     (kg_reg),
        .chan_o  (green_out)
    );

    hsvrgb_chan u_blue (
        .aclk    (aclk),
        .en      (chan_en),
        .scale_i (scale2_reg),
        .k_i     (kb_reg),
        .chan_o  (blue_out)
    );

    assign m_tdata = {blue_out, green_out, red_out};

`ifndef SYNTHESIS
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld1_reg && vld2_reg && vld3_reg && vld4_reg && vld5_reg && !m_tready)
        |-> !s_tready)
        else $error("input accepted into a full pipeline");

    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld1_reg && !adv2) |=> vld1_reg)
        else $error("stalled word dropped from stage 1");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");
`endif

endmodule
